/* rtl/core/mqrb_pkg.sv */
package mqrb_pkg;

  // default sizes of the queue bank
  localparam int NUM_QUEUES_DEF = 16;
  localparam int DEPTH_DEF      = 16;

  // field widths fixed by the request format
  localparam int FUNC_W   = 1;
  localparam int QID_W    = 8;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_PUSH = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_POP  = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BAD_ID = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_RESP
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;   // latch request fields, read pointer pair
    logic exec;      // register result status
    logic slot_wr;   // store pushed word
    logic slot_rd;   // read oldest word
    logic ptr_wr;    // write back pointer pair
    logic resp;      // result on the output ports
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic bad_id;
    logic is_pop;
    logic full;
    logic empty;
  } stat_t;

endpackage

/* rtl/core/mqrb_ctrl.sv */
module mqrb_ctrl
  import mqrb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  stat_t stat,
  output logic  busy,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_CHECK;
      end
      S_CHECK: state_nxt = S_RESP;
      S_RESP:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      S_CHECK: begin
        cmd.exec    = 1'b1;
        cmd.slot_wr = !stat.bad_id && !stat.is_pop && !stat.full;
        cmd.slot_rd = !stat.bad_id && stat.is_pop && !stat.empty;
        cmd.ptr_wr  = cmd.slot_wr || cmd.slot_rd;
      end
      S_RESP: begin
        cmd.resp = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

/* rtl/core/mqrb_datapath.sv */
module mqrb_datapath
  import mqrb_pkg::*;
#(
  parameter int NUM_QUEUES = NUM_QUEUES_DEF,
  parameter int DEPTH      = DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [QID_W-1:0]    in_queue_id,
  input  logic [WORD_W-1:0]   in_push_word,
  output stat_t               stat,
  output logic [STATUS_W-1:0] out_status,
  output logic [WORD_W-1:0]   out_pop_word
);

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int QN = 1 << QW;
  localparam int PW = $clog2(DEPTH);
  localparam int SN = 1 << (QW + PW);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [QID_W-1:0] QID_MAX = QID_W'(NUM_QUEUES);

  // pointer pair store {write, read} with per-queue valid bits
  logic [2*PW-1:0]   ptr_mem [QN];
  logic [QN-1:0]     ptr_vld_r;
  logic [2*PW-1:0]   ptr_rd_r;
  logic              ptr_rd_vld_r;
  logic [WORD_W-1:0] slot_mem [SN];
  logic [WORD_W-1:0] slot_rd_r;

  logic [FUNC_W-1:0] func_r;
  logic [QID_W-1:0]  qid_r;
  logic [QW-1:0]     q_r;
  logic [WORD_W-1:0] word_r;
  status_t           status_r;
  logic              pop_ok_r;

  logic [QW-1:0] q_in;
  logic [PW-1:0] wp, rp, wp_adv, rp_adv;
  status_t       status_nxt;

  assign q_in = QW'(in_queue_id - QID_W'(1));

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      qid_r  <= in_queue_id;
      q_r    <= q_in;
      word_r <= in_push_word;
    end
  end

  // pointer read at the incoming queue, registered
  always_ff @(posedge clk) begin
    ptr_rd_r <= ptr_mem[q_in];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_vld_r    <= '0;
      ptr_rd_vld_r <= 1'b0;
    end else begin
      ptr_rd_vld_r <= ptr_vld_r[q_in];
      if (cmd.ptr_wr) ptr_vld_r[q_r] <= 1'b1;
    end
  end

  // unwritten queue reads as both pointers zero
  assign wp = ptr_rd_vld_r ? ptr_rd_r[2*PW-1:PW] : '0;
  assign rp = ptr_rd_vld_r ? ptr_rd_r[PW-1:0]    : '0;

  // pointer advance with wrap
  assign wp_adv = (wp == PTR_LAST) ? '0 : wp + PW'(1);
  assign rp_adv = (rp == PTR_LAST) ? '0 : rp + PW'(1);

  // queue checks
  always_comb begin
    stat.bad_id = (qid_r == '0) || (qid_r > QID_MAX);
    stat.is_pop = (func_r == FUNC_POP);
    stat.full   = (wp_adv == rp);
    stat.empty  = (wp == rp);
  end

  // pointer write-back
  always_ff @(posedge clk) begin
    if (cmd.ptr_wr) begin
      ptr_mem[q_r] <= cmd.slot_wr ? {wp_adv, rp} : {wp, rp_adv};
    end
  end

  // slot store
  always_ff @(posedge clk) begin
    if (cmd.slot_wr) slot_mem[{q_r, wp}] <= word_r;
    if (cmd.slot_rd) slot_rd_r <= slot_mem[{q_r, rp}];
  end

  // result status
  always_comb begin
    if (stat.bad_id) begin
      status_nxt = ST_BAD_ID;
    end else if (stat.is_pop) begin
      status_nxt = stat.empty ? ST_EMPTY : ST_OK;
    end else begin
      status_nxt = stat.full ? ST_FULL : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= status_nxt;
      pop_ok_r <= cmd.slot_rd;
    end
  end

  assign out_status   = status_r;
  assign out_pop_word = pop_ok_r ? slot_rd_r : '0;

endmodule

/* rtl/core/multi_queue_ring_buffer_top.sv */
// the result strobe comes in the result state, after the check state that follows acceptance
// each request goes through pointer read, check and result steps; the next is taken only when idle
// each result is shown for one cycle on out_valid; the receiver cannot stall
// reset: synchronous active-low rst_n empties every queue at once through per-queue
// pointer valid bits; slot storage is not cleared
module multi_queue_ring_buffer_top
  import mqrb_pkg::*;
#(
  parameter int NUM_QUEUES = NUM_QUEUES_DEF,
  parameter int DEPTH      = DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [QID_W-1:0]    in_queue_id,
  input  logic [WORD_W-1:0]   in_push_word,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [WORD_W-1:0]   out_pop_word
);

  cmd_t  cmd;
  stat_t stat;

  // sequencing
  mqrb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // pointers, slots and result
  mqrb_datapath #(
    .NUM_QUEUES (NUM_QUEUES),
    .DEPTH      (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_func      (in_func),
    .in_queue_id  (in_queue_id),
    .in_push_word (in_push_word),
    .stat         (stat),
    .out_status   (out_status),
    .out_pop_word (out_pop_word)
  );

  assign out_valid = cmd.resp;

endmodule

/* rtl/core/mqrb_checker.sv */
module mqrb_checker
  import mqrb_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic [FUNC_W-1:0]   in_func,
  input logic [QID_W-1:0]    in_queue_id,
  input logic                out_valid,
  input logic [STATUS_W-1:0] out_status,
  input logic [WORD_W-1:0]   out_pop_word
);

  // accepted request gives its result strobe after the check state
  a_resp_timing: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("result strobe missing after accepted request");

  // no new request taken while one is in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted request");

  // failed operations return a zero word
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_pop_word == '0))
    else $error("nonzero word on failed operation");

  // queue number zero is always rejected
  a_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_queue_id == '0) |-> ##2 (out_status == ST_BAD_ID))
    else $error("queue number zero not rejected");

  // push never returns a word
  a_push_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == FUNC_PUSH) |-> ##2 (out_pop_word == '0))
    else $error("push returned a word");

endmodule

bind multi_queue_ring_buffer_top mqrb_checker u_mqrb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_func      (in_func),
  .in_queue_id  (in_queue_id),
  .out_valid    (out_valid),
  .out_status   (out_status),
  .out_pop_word (out_pop_word)
);

/* tb/tb_multi_queue_ring_buffer_top.sv */
`timescale 1ns / 1ps

module tb_multi_queue_ring_buffer_top;
  import mqrb_pkg::*;

  // one predicted result of the queue bank
  typedef struct {
    status_t           status;
    logic [WORD_W-1:0] word;
  } bank_result_t;

  // predictor of the fifo bank plus the store of results still owed
  class fifo_bank_model;
    localparam int PTR_W = $clog2(DEPTH_DEF);

    logic [PTR_W-1:0]  wr_ptr [NUM_QUEUES_DEF];
    logic [PTR_W-1:0]  rd_ptr [NUM_QUEUES_DEF];
    logic [WORD_W-1:0] slot_mem [NUM_QUEUES_DEF*DEPTH_DEF];
    bank_result_t      owed_results [$];
    int                errors;
    int                requests;
    int                status_seen [4];

    function new();
      foreach (wr_ptr[i]) begin
        wr_ptr[i] = '0;
        rd_ptr[i] = '0;
      end
      errors   = 0;
      requests = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function logic [PTR_W-1:0] step_ptr(logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH_DEF - 1)) ? '0 : p + 1'b1;
    endfunction

    // accepted request: update the queue state and queue up its result
    function void note_request(logic [FUNC_W-1:0] f, logic [QID_W-1:0] qid,
                               logic [WORD_W-1:0] w);
      bank_result_t     r;
      int               q;
      logic [PTR_W-1:0] nxt;
      r.status = ST_OK;
      r.word   = '0;
      requests++;
      if (qid == 0 || qid > NUM_QUEUES_DEF) begin
        r.status = ST_BAD_ID;
      end else begin
        q = qid - 1;
        if (f == FUNC_PUSH) begin
          nxt = step_ptr(wr_ptr[q]);
          if (nxt == rd_ptr[q]) begin
            r.status = ST_FULL;
          end else begin
            slot_mem[q*DEPTH_DEF + wr_ptr[q]] = w;
            wr_ptr[q] = nxt;
          end
        end else begin
          if (wr_ptr[q] == rd_ptr[q]) begin
            r.status = ST_EMPTY;
          end else begin
            r.word    = slot_mem[q*DEPTH_DEF + rd_ptr[q]];
            rd_ptr[q] = step_ptr(rd_ptr[q]);
          end
        end
      end
      owed_results.push_back(r);
    endfunction

    // compare one strobed result with the oldest owed one
    function void check_result(logic [STATUS_W-1:0] st, logic [WORD_W-1:0] w);
      bank_result_t r;
      if (owed_results.size() == 0) begin
        $error("unexpected result: status %0d pop_word 0x%08h", st, w);
        errors++;
        return;
      end
      r = owed_results.pop_front();
      status_seen[r.status]++;
      if (st !== r.status) begin
        $error("status mismatch: expected %0d, actual %0d", r.status, st);
        errors++;
      end
      if (w !== r.word) begin
        $error("pop_word mismatch: expected 0x%08h, actual 0x%08h", r.word, w);
        errors++;
      end
    endfunction

    function int outstanding();
      return owed_results.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [FUNC_W-1:0]   in_func = FUNC_PUSH;
  logic [QID_W-1:0]    in_queue_id = '0;
  logic [WORD_W-1:0]   in_push_word = '0;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [WORD_W-1:0]   out_pop_word;

  fifo_bank_model bank_model;

  multi_queue_ring_buffer_top uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_func      (in_func),
    .in_queue_id  (in_queue_id),
    .in_push_word (in_push_word),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_pop_word (out_pop_word)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watch both channels at every edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) bank_model.check_result(out_status, out_pop_word);
      if (start && !busy) bank_model.note_request(in_func, in_queue_id, in_push_word);
    end
  end

  // drop start through the gap, then present the request until taken
  task automatic send_request(input logic [FUNC_W-1:0] f, input logic [QID_W-1:0] qid,
                              input logic [WORD_W-1:0] w, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_func      <= f;
    in_queue_id  <= qid;
    in_push_word <= w;
    do @(posedge clk); while (busy);
  endtask

  // mostly valid queues, a few bad ids of both kinds
  function automatic logic [QID_W-1:0] pick_queue(bit narrow);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return '0;
    if (roll < 8) return QID_W'($urandom_range(NUM_QUEUES_DEF + 1, 255));
    if (narrow) return QID_W'($urandom_range(1, 3));
    return QID_W'($urandom_range(1, NUM_QUEUES_DEF));
  endfunction

  // random traffic with a given push bias; narrow keeps it on a few queues
  task automatic random_phase(input int count, input int push_pct, input bit narrow,
                              input int max_gap);
    logic [FUNC_W-1:0] f;
    for (int i = 0; i < count; i++) begin
      f = ($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP;
      send_request(f, pick_queue(narrow), $urandom, $urandom_range(0, max_gap));
    end
  endtask

  // main sequence
  initial begin
    bank_model = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bad ids at both ends
    send_request(FUNC_PUSH, 8'd0, 32'h1234_5678, $urandom_range(0, 5));
    send_request(FUNC_POP, QID_W'(NUM_QUEUES_DEF + 1), 32'h0, $urandom_range(0, 5));
    send_request(FUNC_PUSH, 8'hff, 32'hffff_ffff, $urandom_range(0, 5));
    // empty pop, extreme words through the first queue
    send_request(FUNC_POP, 8'd1, 32'h0, $urandom_range(0, 5));
    send_request(FUNC_PUSH, 8'd1, 32'h0000_0000, $urandom_range(0, 5));
    send_request(FUNC_PUSH, 8'd1, 32'hffff_ffff, $urandom_range(0, 5));
    send_request(FUNC_POP, 8'd1, 32'hffff_ffff, $urandom_range(0, 5));
    send_request(FUNC_POP, 8'd1, 32'h0, $urandom_range(0, 5));
    send_request(FUNC_POP, 8'd1, 32'h0, $urandom_range(0, 5));
    // fill the last queue, then push once more into a full queue
    for (int i = 0; i < DEPTH_DEF; i++)
      send_request(FUNC_PUSH, QID_W'(NUM_QUEUES_DEF), $urandom, $urandom_range(0, 5));

    // random traffic in push-heavy and pop-heavy phases to reach full and pointer wrap
    random_phase(150, 75, 1'b1, 5);
    random_phase(100, 30, 1'b1, 0);
    random_phase(150, 55, 1'b0, 5);
    random_phase(100, 70, 1'b1, 2);
    random_phase(100, 20, 1'b0, 5);
    start <= 1'b0;

    // drain
    while (bank_model.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d requests checked: %0d ok, %0d bad id, %0d full, %0d empty",
             bank_model.requests, bank_model.status_seen[ST_OK],
             bank_model.status_seen[ST_BAD_ID], bank_model.status_seen[ST_FULL],
             bank_model.status_seen[ST_EMPTY]);
    if (bank_model.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("timeout waiting for results");
    $display("Verification failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/mqrb_pkg.sv
rtl/core/mqrb_ctrl.sv
rtl/core/mqrb_datapath.sv
rtl/core/multi_queue_ring_buffer_top.sv
rtl/core/mqrb_checker.sv
tb/tb_multi_queue_ring_buffer_top.sv
